// ===== sv/jfp_pkg.sv =====
// Shared types, sizes and codes of the joint frame parser.
`timescale 1ns / 1ps
`default_nettype none

package jfp_pkg;

    // Largest entry count a frame may carry.
    localparam int MAX_ENTRIES = 5;
    // Bytes per entry: id byte plus four angle bytes.
    localparam int ENTRY_BYTES = 5;
    localparam int STORE_DEPTH = MAX_ENTRIES * ENTRY_BYTES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = $clog2(STORE_DEPTH + 1);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W       = $clog2(ENTRY_BYTES);

    // APB register map
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_FIRST_SYNC  = 2'd0;
    localparam logic [1:0] REG_SECOND_SYNC = 2'd1;
    localparam logic [1:0] REG_TIMEOUT     = 2'd2;

    localparam logic [7:0] FIRST_SYNC_RST  = 8'hAA;
    localparam logic [7:0] SECOND_SYNC_RST = 8'h55;
    localparam logic [7:0] TIMEOUT_RST     = 8'd50;

    // Input action codes
    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_LERR  = 2'd2;

    // Result status codes
    localparam logic STAT_OK     = 1'b0;
    localparam logic STAT_BADSUM = 1'b1;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  joint_id;
        logic        id_in_range;
        logic [31:0] angle_bits;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [7:0] first_sync;
        logic [7:0] second_sync;
        logic [7:0] timeout;
    } cfg_t;

endpackage

`default_nettype wire

// ===== sv/joint_frame_parser_xor_check_unit.sv =====
// Joint frame parser: sync hunt, count, payload buffer in RAM, XOR check, entry emit.
//
// Each input item is a received byte, a millisecond tick or a line-error
// event. Most items leave s_ready high. The checksum byte of a frame is
// the exception. A bad checksum queues one error result, which waits in
// ST_PUSH for the output register. A good checksum replays the buffered
// payload out of the payload RAM through its single registered read
// port, each byte passing ST_RD and then ST_CAP, and each entry then
// passing ST_PUSH, which waits for the output register; no new item is
// taken until the last entry of the frame is pushed. The output
// register decouples the sides: the last result of a frame can wait on
// m_ready while new items flow in.
// Payload bytes are written only while hunting/receiving and read only
// during replay, so the RAM never sees a write and read of the same entry
// in flight. Entries never written in the current frame are never read.
// Configuration (sync bytes, idle timeout) sits behind the APB port.
`timescale 1ns / 1ps
`default_nettype none

module joint_frame_parser_xor_check_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // input item channel
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire jfp_pkg::in_t                s_data,
    // result item channel
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output jfp_pkg::out_t                    m_data,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [jfp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    localparam int ADDR_W = jfp_pkg::ADDR_W;
    localparam int IDX_W  = jfp_pkg::IDX_W;
    localparam int CNT_W  = jfp_pkg::CNT_W;
    localparam int POS_W  = jfp_pkg::POS_W;

    typedef enum logic [1:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_COUNT,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_CAP,
        ST_PUSH
    } ctl_t;

    jfp_pkg::cfg_t cfg;

    jfp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------- state ----------------
    phase_t            phase_reg,     phase_next;
    ctl_t              ctl_reg,       ctl_next;
    logic [7:0]        idle_reg,      idle_next;
    logic [CNT_W-1:0]  total_reg,     total_next;
    logic [IDX_W-1:0]  flen_reg,      flen_next;   // total * entry bytes
    logic [IDX_W-1:0]  pidx_reg,      pidx_next;
    logic [7:0]        xor_reg,       xor_next;
    logic              err_reg,       err_next;    // pending result is bad sum
    logic [CNT_W-1:0]  ent_reg,       ent_next;    // entry being replayed
    logic [POS_W-1:0]  pos_reg,       pos_next;    // byte within entry
    logic [ADDR_W-1:0] raddr_reg,     raddr_next;
    logic [7:0]        id_reg,        id_next;
    logic [31:0]       ang_reg,       ang_next;
    logic              m_valid_reg,   m_valid_next;
    jfp_pkg::out_t     m_data_reg,    m_data_next;

    // ---------------- payload RAM ----------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    jfp_ram #(
        .WIDTH (8),
        .DEPTH (jfp_pkg::STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (raddr_reg),
        .rdata (ram_rdata)
    );

    logic       accept;
    logic       out_free;
    logic [7:0] b;
    logic [7:0] idle_inc;
    logic       last_ent;
    logic       id_ok;

    assign s_ready  = (ctl_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign b        = s_data.rx_byte;
    assign idle_inc = (idle_reg == 8'hFF) ? idle_reg : idle_reg + 8'd1;
    assign last_ent = ((ent_reg + CNT_W'(1)) == total_reg);
    assign id_ok    = (id_reg >= 8'd1) && (id_reg <= 8'(jfp_pkg::MAX_ENTRIES));

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign ram_waddr = pidx_reg[ADDR_W-1:0];
    assign ram_wdata = b;

    always_comb begin
        phase_next   = phase_reg;
        ctl_next     = ctl_reg;
        idle_next    = idle_reg;
        total_next   = total_reg;
        flen_next    = flen_reg;
        pidx_next    = pidx_reg;
        xor_next     = xor_reg;
        err_next     = err_reg;
        ent_next     = ent_reg;
        pos_next     = pos_reg;
        raddr_next   = raddr_reg;
        id_next      = id_reg;
        ang_next     = ang_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (ctl_reg)
            ST_IDLE: begin
                if (accept) begin
                    priority case (s_data.action)
                        jfp_pkg::ACT_BYTE: begin
                            idle_next = 8'd0;
                            unique case (phase_reg)
                                PH_HUNT1: begin
                                    if (b == cfg.first_sync) phase_next = PH_HUNT2;
                                end
                                PH_HUNT2: begin
                                    // equal sync registers: second sync wins
                                    if (b == cfg.second_sync) begin
                                        phase_next = PH_COUNT;
                                    end else if (b != cfg.first_sync) begin
                                        phase_next = PH_HUNT1;
                                    end
                                end
                                PH_COUNT: begin
                                    if (b == 8'd0 || b > 8'(jfp_pkg::MAX_ENTRIES)) begin
                                        phase_next = PH_HUNT1;
                                    end else begin
                                        total_next = b[CNT_W-1:0];
                                        flen_next  = IDX_W'(b[CNT_W-1:0])
                                                   * IDX_W'(jfp_pkg::ENTRY_BYTES);
                                        xor_next   = b;
                                        pidx_next  = '0;
                                        phase_next = PH_PAYLOAD;
                                    end
                                end
                                PH_PAYLOAD: begin
                                    if (pidx_reg < flen_reg) begin
                                        ram_we    = 1'b1;
                                        xor_next  = xor_reg ^ b;
                                        pidx_next = pidx_reg + IDX_W'(1);
                                    end else begin
                                        // checksum byte closes the frame
                                        phase_next = PH_HUNT1;
                                        pidx_next  = '0;
                                        if (b != xor_reg) begin
                                            err_next = 1'b1;
                                            ctl_next = ST_PUSH;
                                        end else begin
                                            err_next   = 1'b0;
                                            ent_next   = '0;
                                            pos_next   = '0;
                                            raddr_next = '0;
                                            ctl_next   = ST_RD;
                                        end
                                    end
                                end
                                default: ;
                            endcase
                        end
                        jfp_pkg::ACT_TICK: begin
                            idle_next = idle_inc;
                            if (phase_reg != PH_HUNT1 && idle_inc > cfg.timeout) begin
                                phase_next = PH_HUNT1;
                                pidx_next  = '0;
                            end
                        end
                        jfp_pkg::ACT_LERR: begin
                            phase_next = PH_HUNT1;
                            pidx_next  = '0;
                        end
                        default: ;  // unused action code
                    endcase
                end
            end
            ST_RD: begin
                // address is on the RAM this cycle, data lands next cycle
                ctl_next = ST_CAP;
            end
            ST_CAP: begin
                raddr_next = raddr_reg + ADDR_W'(1);
                if (pos_reg == '0) begin
                    id_next = ram_rdata;
                end else begin
                    ang_next = {ram_rdata, ang_reg[31:8]};
                end
                if (pos_reg == POS_W'(jfp_pkg::ENTRY_BYTES - 1)) begin
                    ctl_next = ST_PUSH;
                end else begin
                    pos_next = pos_reg + POS_W'(1);
                    ctl_next = ST_RD;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (err_reg) begin
                        m_data_next.status      = jfp_pkg::STAT_BADSUM;
                        m_data_next.joint_id    = 8'd0;
                        m_data_next.id_in_range = 1'b0;
                        m_data_next.angle_bits  = 32'd0;
                        m_data_next.last        = 1'b1;
                        ctl_next                = ST_IDLE;
                    end else begin
                        m_data_next.status      = jfp_pkg::STAT_OK;
                        m_data_next.joint_id    = id_reg;
                        m_data_next.id_in_range = id_ok;
                        m_data_next.angle_bits  = ang_reg;
                        m_data_next.last        = last_ent;
                        if (last_ent) begin
                            ctl_next = ST_IDLE;
                        end else begin
                            ent_next = ent_reg + CNT_W'(1);
                            pos_next = '0;
                            ctl_next = ST_RD;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT1;
            ctl_reg     <= ST_IDLE;
            idle_reg    <= 8'd0;
            total_reg   <= '0;
            flen_reg    <= '0;
            pidx_reg    <= '0;
            xor_reg     <= 8'd0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            ctl_reg     <= ctl_next;
            idle_reg    <= idle_next;
            total_reg   <= total_next;
            flen_reg    <= flen_next;
            pidx_reg    <= pidx_next;
            xor_reg     <= xor_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
        ent_reg    <= ent_next;
        pos_reg    <= pos_next;
        raddr_reg  <= raddr_next;
        id_reg     <= id_next;
        ang_reg    <= ang_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

// ===== sv/jfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module jfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/jfp_cfg.sv =====
// APB register file: sync bytes and idle timeout.
`timescale 1ns / 1ps
`default_nettype none

module jfp_cfg (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [jfp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output jfp_pkg::cfg_t                    cfg
);

    jfp_pkg::cfg_t cfg_reg;
    logic [1:0]    reg_sel;
    logic          wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_sync  <= jfp_pkg::FIRST_SYNC_RST;
            cfg_reg.second_sync <= jfp_pkg::SECOND_SYNC_RST;
            cfg_reg.timeout     <= jfp_pkg::TIMEOUT_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                jfp_pkg::REG_FIRST_SYNC:  cfg_reg.first_sync  <= pwdata[7:0];
                jfp_pkg::REG_SECOND_SYNC: cfg_reg.second_sync <= pwdata[7:0];
                jfp_pkg::REG_TIMEOUT:     cfg_reg.timeout     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            jfp_pkg::REG_FIRST_SYNC:  prdata = {24'd0, cfg_reg.first_sync};
            jfp_pkg::REG_SECOND_SYNC: prdata = {24'd0, cfg_reg.second_sync};
            jfp_pkg::REG_TIMEOUT:     prdata = {24'd0, cfg_reg.timeout};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire
